// ===== src/smac_pkg.sv =====
// Shared types and constants for the shadow memory access checker.
// Depends on nothing; used by all modules under src.
`default_nettype none
package smac_pkg;
  localparam int SHADOW_ENTRIES = 65536;
  localparam int SHADOW_AW      = $clog2(SHADOW_ENTRIES);

  localparam logic [1:0] KIND_CHECK    = 2'd0;
  localparam logic [1:0] KIND_MARK     = 2'd1;
  localparam logic [1:0] KIND_FILL     = 2'd2;
  localparam logic [1:0] KIND_UNPOISON = 2'd3;

  localparam logic [2:0] CFG_ENABLE      = 3'd0;
  localparam logic [2:0] CFG_REGION_BASE = 3'd1;
  localparam logic [2:0] CFG_WR_OFFSET   = 3'd2;
  localparam logic [2:0] CFG_REGION_SIZE = 3'd3;
  localparam logic [2:0] CFG_SHADOW_BASE = 3'd4;

  localparam logic [7:0] CLASS_ILLEGAL = 8'hFF;

  typedef struct packed {
    logic clr;
    logic load;
    logic prep;
    logic step;
    logic eval;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic work_done;
    logic is_check;
    logic out_busy;
  } status_t;
endpackage
`default_nettype wire

// ===== src/smac_datapath.sv =====
// Datapath: config registers, item registers, granule iterator, shadow RAM, result register.
// Depends on smac_pkg; driven by smac_ctrl commands.
`default_nettype none
module smac_datapath (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_wr_en,
  input  wire [2:0]          cfg_addr,
  input  wire [63:0]         cfg_wdata,
  input  wire [1:0]          in_kind,
  input  wire [119:0]        in_data,
  input  wire                out_tready,
  input  smac_pkg::cmd_t     cmd,
  output smac_pkg::status_t  st,
  output logic               out_valid,
  output logic               out_viol,
  output logic [7:0]         out_class
);
  localparam int SHADOW_AW_W = smac_pkg::SHADOW_AW;

  logic        enable_r;
  logic [63:0] base_r, swb_r;
  logic [31:0] woff_r, rsize_r;
  logic [63:0] wstart_r, rend_r, wsize_r;

  logic [1:0]  kind_r;
  logic [63:0] addr_r;
  logic [19:0] len_r, ext_r;
  logic [7:0]  code_r;
  logic        wr_r;

  logic        viol_r;
  logic [7:0]  class_r;
  logic [19:0] rem_r;
  logic [2:0]  off_r;
  logic [60:0] g_r;
  logic [17:0] z_r, r_r;
  logic        p_r;
  logic        cov_q;
  logic [2:0]  hi_q;
  logic [7:0]  rdata_r;
  logic [SHADOW_AW_W-1:0] clr_idx_r;
  logic        out_valid_r, out_viol_r;
  logic [7:0]  out_class_r;

  logic [7:0] mem [smac_pkg::SHADOW_ENTRIES];

  // prep terms
  logic [63:0] win_off;
  logic        ill, unsup, chk_on;
  logic        ill_hit, run_bytes, mark_go, fill_go;
  logic [20:0] rounded, ext_w, redz;
  // step terms
  logic [60:0] gdiff;
  logic        cov, byte_mode, last_b;
  logic [SHADOW_AW_W-1:0] idx;
  logic [3:0]  take;
  logic [2:0]  hi;
  logic [7:0]  gval, s;
  logic        fail;
  logic        we;
  logic [SHADOW_AW_W-1:0] waddr;
  logic [7:0]  wdata;

  always_comb begin
    win_off = addr_r - swb_r;
    ill     = (win_off < wsize_r) || (wr_r && addr_r >= base_r && addr_r < wstart_r);
    unsup   = (addr_r > rend_r) || (addr_r < base_r);
    chk_on  = enable_r && (len_r != 20'd0);
    rounded = ({1'b0, len_r} + 21'd7) & ~21'd7;
    ext_w   = {1'b0, ext_r};
    redz    = (ext_w > rounded) ? (ext_w - rounded) : 21'd0;

    ill_hit   = (kind_r == smac_pkg::KIND_CHECK) && chk_on && ill;
    run_bytes = (kind_r == smac_pkg::KIND_UNPOISON) ||
                ((kind_r == smac_pkg::KIND_CHECK) && chk_on && !ill && !unsup);
    mark_go   = (kind_r == smac_pkg::KIND_MARK) && !unsup;
    fill_go   = (kind_r == smac_pkg::KIND_FILL) && !unsup;

    gdiff     = g_r - wstart_r[63:3];
    cov       = (g_r >= wstart_r[63:3]) && (gdiff[60:SHADOW_AW_W] == '0);
    idx       = gdiff[SHADOW_AW_W-1:0];
    byte_mode = (kind_r == smac_pkg::KIND_CHECK) || (kind_r == smac_pkg::KIND_UNPOISON);
    take      = 4'd8 - {1'b0, off_r};
    last_b    = (rem_r <= {16'd0, take});
    hi        = last_b ? (off_r + rem_r[2:0] - 3'd1) : 3'd7;
    gval      = (z_r != '0) ? 8'd0 : (p_r ? {5'd0, len_r[2:0]} : code_r);

    s    = cov_q ? rdata_r : 8'd0;
    fail = (s != 8'd0) && (s[7] || ((s[6:3] == 4'd0) && (hi_q >= s[2:0])));

    we    = cmd.clr || (cmd.step && cov && (kind_r != smac_pkg::KIND_CHECK));
    waddr = cmd.clr ? clr_idx_r : idx;
    if (cmd.clr) begin
      wdata = 8'd0;
    end else if (byte_mode) begin
      wdata = {4'd0, {1'b0, hi} + 4'd1};
    end else begin
      wdata = gval;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      base_r   <= '0;
      woff_r   <= '0;
      rsize_r  <= '0;
      swb_r    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        smac_pkg::CFG_ENABLE:      enable_r <= cfg_wdata[0];
        smac_pkg::CFG_REGION_BASE: base_r   <= cfg_wdata;
        smac_pkg::CFG_WR_OFFSET:   woff_r   <= cfg_wdata[31:0];
        smac_pkg::CFG_REGION_SIZE: rsize_r  <= cfg_wdata[31:0];
        smac_pkg::CFG_SHADOW_BASE: swb_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    wstart_r <= base_r + {32'd0, woff_r};
    rend_r   <= base_r + {32'd0, rsize_r};
    wsize_r  <= ({32'd0, rsize_r} - {32'd0, woff_r} + 64'd1) >> 3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr) begin
      clr_idx_r <= clr_idx_r + SHADOW_AW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      addr_r  <= in_data[63:0];
      len_r   <= in_data[83:64];
      ext_r   <= in_data[103:84];
      code_r  <= in_data[111:104];
      wr_r    <= in_data[112];
      viol_r  <= 1'b0;
      class_r <= 8'd0;
    end
    if (cmd.prep) begin
      g_r   <= addr_r[63:3];
      off_r <= addr_r[2:0];
      rem_r <= run_bytes ? len_r : 20'd0;
      z_r   <= mark_go ? {1'b0, len_r[19:3]} : 18'd0;
      p_r   <= mark_go && (len_r[2:0] != 3'd0);
      r_r   <= mark_go ? redz[20:3] : (fill_go ? {1'b0, len_r[19:3]} : 18'd0);
      if (ill_hit) begin
        viol_r  <= 1'b1;
        class_r <= smac_pkg::CLASS_ILLEGAL;
      end
    end
    if (cmd.step) begin
      cov_q <= cov;
      hi_q  <= hi;
      if (byte_mode) begin
        if (last_b) begin
          rem_r <= 20'd0;
        end else begin
          rem_r <= rem_r - {16'd0, take};
          off_r <= 3'd0;
          g_r   <= g_r + 61'd1;
        end
      end else begin
        g_r <= g_r + 61'd1;
        if (z_r != '0) begin
          z_r <= z_r - 18'd1;
        end else if (p_r) begin
          p_r <= 1'b0;
        end else begin
          r_r <= r_r - 18'd1;
        end
      end
    end
    if (cmd.eval && fail) begin
      viol_r  <= 1'b1;
      class_r <= s;
      rem_r   <= 20'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_viol_r  <= viol_r;
      out_class_r <= viol_r ? class_r : 8'd0;
    end
  end

  assign st.clr_last  = &clr_idx_r;
  assign st.work_done = (rem_r == 20'd0) && (z_r == '0) && !p_r && (r_r == '0);
  assign st.is_check  = (kind_r == smac_pkg::KIND_CHECK);
  assign st.out_busy  = out_valid_r && !out_tready;
  assign out_valid    = out_valid_r;
  assign out_viol     = out_viol_r;
  assign out_class    = out_class_r;
endmodule
`default_nettype wire

// ===== src/smac_ctrl.sv =====
// Controller state machine: clearing pass, request intake, granule walk, result hand-off.
// Depends on smac_pkg; commands smac_datapath.
`default_nettype none
module smac_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_tvalid,
  output logic               in_tready,
  input  smac_pkg::status_t  st,
  output smac_pkg::cmd_t     cmd
);
  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_STEP = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (st.work_done) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.step = 1'b1;
          if (st.is_check) begin
            state_nxt = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_STEP;
      end
      ST_FIN: begin
        if (!st.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== src/shadow_memory_access_checker_core.sv =====
// Top level of the shadow memory access checker.
// Depends on smac_pkg, smac_ctrl and smac_datapath.
//
// channel  dir  handshake            payload
// in_      in   in_tvalid/in_tready  tuser kind, tdata address..store flag
// out_     out  out_tvalid/out_tready tuser violation, tdata violation_class
// cfg_     in   cfg_wr_en            cfg_addr index, cfg_wdata value
//
// After reset a clearing pass zeroes the 65536-entry shadow RAM, one entry per
// cycle; in_tready stays low meanwhile.
// A check visits each granule touched in ST_STEP (RAM read) and then ST_CHK (compare);
// mark, fill and unpoison write one granule in each ST_STEP.
// A new request is taken while the previous result waits on out_tready.
`default_nettype none
module shadow_memory_access_checker_core (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          cfg_wr_en,
  input  wire  [2:0]   cfg_addr,
  input  wire  [63:0]  cfg_wdata,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [1:0]   in_tuser,   // kind
  input  wire  [119:0] in_tdata,   // address, length, extent, poison_code, store flag, zero pad
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic         out_tuser,  // violation
  output logic [7:0]   out_tdata   // violation_class
);
  smac_pkg::cmd_t    cmd;
  smac_pkg::status_t st;

  smac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  smac_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_kind    (in_tuser),
    .in_data    (in_tdata),
    .out_tready (out_tready),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (out_tvalid),
    .out_viol   (out_tuser),
    .out_class  (out_tdata)
  );

  a_clean_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == 8'd0))
    else $error("class set without violation");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while busy");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("ready before clearing pass");
endmodule
`default_nettype wire

// ===== tb/tb_shadow_memory_access_checker_core.sv =====
// Self-checking testbench for shadow_memory_access_checker_core.
// Depends on smac_pkg and the core; drives requests, predicts each result
// from a private shadow copy and compares them in order.
`timescale 1ns / 100ps
`default_nettype none
module tb_shadow_memory_access_checker_core;
  localparam int IDLE_LIMIT = 400000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic [2:0]   cfg_addr = '0;
  logic [63:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [1:0]   in_tuser = '0;
  logic [119:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         out_tuser;
  logic [7:0]   out_tdata;

  typedef struct packed {
    logic       violation;
    logic [7:0] vclass;
  } verdict_t;

  verdict_t    verdict_q[$];
  bit [7:0]    shadow_copy [smac_pkg::SHADOW_ENTRIES];
  logic        en_r;
  logic [63:0] base_r, win_r;
  logic [31:0] woff_r, size_r;
  int          errors = 0;
  bit          calm = 1'b0;
  int          idle_cycles = 0;

  shadow_memory_access_checker_core uut (.*);

  always #1 clk = ~clk;

  // ---------------- predictor ----------------
  function automatic logic [63:0] wstart_of();
    return base_r + {32'd0, woff_r};
  endfunction

  function automatic bit covered(input logic [63:0] g, output int idx);
    logic [63:0] g0;
    g0 = wstart_of() >> 3;
    idx = 0;
    if (g < g0 || (g - g0) >= smac_pkg::SHADOW_ENTRIES) return 1'b0;
    idx = int'(g - g0);
    return 1'b1;
  endfunction

  function automatic logic [7:0] shadow_rd(input logic [63:0] g);
    int idx;
    if (!covered(g, idx)) return 8'd0;
    return shadow_copy[idx];
  endfunction

  function automatic void shadow_wr(input logic [63:0] g, input logic [7:0] v);
    int idx;
    if (covered(g, idx)) shadow_copy[idx] = v;
  endfunction

  function automatic bit outside_region(input logic [63:0] a);
    return a > base_r + {32'd0, size_r} || a < base_r;
  endfunction

  function automatic verdict_t apply_request(input logic [1:0] kind, input logic [63:0] a,
      input logic [19:0] len, input logic [19:0] ext, input logic [7:0] code, input bit wr);
    verdict_t    v;
    logic [63:0] wsize, g, b, rounded, redz;
    logic [7:0]  s;
    int          need;
    v = '0;
    g = a >> 3;
    case (kind)
      smac_pkg::KIND_CHECK: begin
        wsize = ({32'd0, size_r} - {32'd0, woff_r} + 64'd1) >> 3;
        if (en_r && len != 0) begin
          if ((a - win_r) < wsize || (wr && a >= base_r && a < wstart_of())) begin
            v = '{1'b1, smac_pkg::CLASS_ILLEGAL};
          end else if (!outside_region(a)) begin
            for (int i = 0; i < len; i++) begin
              b = a + i;
              s = shadow_rd(b >> 3);
              need = int'(b[2:0]) + 1;
              if (s != 0 && $signed({{24{s[7]}}, s}) < need) begin
                v = '{1'b1, s};
                break;
              end
            end
          end
        end
      end
      smac_pkg::KIND_MARK: begin
        if (!outside_region(a)) begin
          rounded = ({44'd0, len} + 64'd7) & ~64'd7;
          redz = ({44'd0, ext} > rounded) ? {44'd0, ext} - rounded : 64'd0;
          for (int i = 0; i < (len >> 3); i++) begin
            shadow_wr(g, 8'd0);
            g = g + 64'd1;
          end
          if (len[2:0] != 0) begin
            shadow_wr(g, {5'd0, len[2:0]});
            g = g + 64'd1;
          end
          for (longint i = 0; i < (redz >> 3); i++) begin
            shadow_wr(g, code);
            g = g + 64'd1;
          end
        end
      end
      smac_pkg::KIND_FILL: begin
        if (len != 0 && !outside_region(a))
          for (int i = 0; i < (len >> 3); i++) shadow_wr(g + i, code);
      end
      default: begin
        for (int i = 0; i < len; i++) begin
          b = a + i;
          shadow_wr(b >> 3, {5'd0, b[2:0]} + 8'd1);
        end
      end
    endcase
    return v;
  endfunction

  // ---------------- drivers ----------------
  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      smac_pkg::CFG_ENABLE:      en_r = val[0];
      smac_pkg::CFG_REGION_BASE: base_r = val;
      smac_pkg::CFG_WR_OFFSET:   woff_r = val[31:0];
      smac_pkg::CFG_REGION_SIZE: size_r = val[31:0];
      default:                   win_r = val;
    endcase
  endtask

  task automatic set_region(input logic en, input logic [63:0] base, input logic [31:0] woff,
      input logic [31:0] size, input logic [63:0] win);
    cfg_write(smac_pkg::CFG_ENABLE, {63'd0, en});
    cfg_write(smac_pkg::CFG_REGION_BASE, base);
    cfg_write(smac_pkg::CFG_WR_OFFSET, {32'd0, woff});
    cfg_write(smac_pkg::CFG_REGION_SIZE, {32'd0, size});
    cfg_write(smac_pkg::CFG_SHADOW_BASE, win);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // valid stays high between requests but for random gaps when not calm; settle() drops it
  task automatic send_request(input logic [1:0] kind, input logic [63:0] a,
      input logic [19:0] len, input logic [19:0] ext, input logic [7:0] code, input bit wr);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'd0, wr, code, ext, len, a};
    do @(posedge clk); while (!in_tready);
    verdict_q.push_back(apply_request(kind, a, len, ext, code, wr));
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %0b/%02h", out_tuser, out_tdata);
      end else begin
        verdict_t w;
        w = verdict_q.pop_front();
        if (out_tuser !== w.violation || out_tdata !== w.vclass) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %0b/%02h got %0b/%02h",
                     w.violation, w.vclass, out_tuser, out_tdata);
        end
      end
    end
  end

  initial begin : sink_stall
    int n;
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm) begin
        n = $urandom_range(1, 13);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------- tests ----------------
  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 4))
      0: return 8'hFA;
      1: return 8'hFB;
      2: return 8'hFD;
      3: return 8'hF2;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [63:0] ws;
    set_region(1'b1, 64'h8000_0000, 32'h100, 32'h4_0000, 64'h1_0000_0000);
    ws = wstart_of();
    send_request(smac_pkg::KIND_CHECK, ws, 20'd0, 20'd0, 8'd0, 1'b0);          // zero length
    send_request(smac_pkg::KIND_CHECK, 64'h1_0000_0005, 20'd4, 20'd0, 8'd0, 1'b0); // window
    send_request(smac_pkg::KIND_CHECK, 64'h8000_0010, 20'd1, 20'd0, 8'd0, 1'b1);  // below wstart
    send_request(smac_pkg::KIND_CHECK, 64'h8000_0010, 20'd1, 20'd0, 8'd0, 1'b0);
    send_request(smac_pkg::KIND_CHECK, 64'h7FFF_FFFF, 20'd8, 20'd0, 8'd0, 1'b0);  // below region
    send_request(smac_pkg::KIND_MARK, ws, 20'd13, 20'd48, 8'hFA, 1'b0);
    send_request(smac_pkg::KIND_CHECK, ws, 20'd13, 20'd0, 8'd0, 1'b0);
    send_request(smac_pkg::KIND_CHECK, ws + 8, 20'd6, 20'd0, 8'd0, 1'b0);        // partial
    send_request(smac_pkg::KIND_CHECK, ws + 20, 20'd4, 20'd0, 8'd0, 1'b1);       // redzone
    send_request(smac_pkg::KIND_MARK, ws + 64, 20'd24, 20'd8, 8'hFB, 1'b0);      // short extent
    send_request(smac_pkg::KIND_FILL, ws + 128, 20'd0, 20'd0, 8'hFD, 1'b0);
    send_request(smac_pkg::KIND_FILL, ws + 128, 20'd31, 20'd0, 8'hF2, 1'b0);
    send_request(smac_pkg::KIND_CHECK, ws + 150, 20'd4, 20'd0, 8'd0, 1'b0);
    send_request(smac_pkg::KIND_UNPOISON, ws + 131, 20'd3, 20'd0, 8'd0, 1'b0);
    send_request(smac_pkg::KIND_CHECK, ws + 128, 20'd8, 20'd0, 8'd0, 1'b0);
    send_request(smac_pkg::KIND_MARK, ws, 20'h8_0000, 20'h8_0000, 8'hFF, 1'b0);
    send_request(smac_pkg::KIND_CHECK, ws + 20, 20'd8, 20'd0, 8'd0, 1'b0);
    send_request(smac_pkg::KIND_UNPOISON, ws + 1, 20'h7_FFFF, 20'd0, 8'd0, 1'b0);
    send_request(smac_pkg::KIND_FILL, 64'hFFFF_FFFF_FFFF_FFFF, 20'h7_FFFF, 20'h7_FFFF,
                 8'hFF, 1'b1);
    send_request(smac_pkg::KIND_MARK, 64'd0, 20'd5, 20'h7_FFFF, 8'hFF, 1'b0);
    send_request(smac_pkg::KIND_UNPOISON, 64'hFFFF_FFFF_FFFF_FFFC, 20'd9, 20'd0, 8'd0,
                 1'b0); // wrap
    send_request(smac_pkg::KIND_CHECK, 64'hFFFF_FFFF_FFFF_FFFC, 20'd9, 20'd0, 8'd0, 1'b0);
    settle();
  endtask

  task automatic test_random(input int count, input logic [31:0] span);
    logic [63:0] a;
    logic [19:0] len, ext;
    logic [1:0]  kind;
    for (int n = 0; n < count; n++) begin
      kind = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) begin
        a = {$urandom, $urandom};
        len = 20'($urandom_range(0, 255));
        ext = 20'($urandom);
      end else begin
        a = ($urandom_range(0, 7) == 0) ? base_r + $urandom_range(0, 32'h300)
                                        : wstart_of() + $urandom_range(0, span);
        len = (kind == smac_pkg::KIND_CHECK) ? 20'($urandom_range(1, 16))
                                             : 20'($urandom_range(0, 64));
        ext = len + 20'($urandom_range(0, 64));
      end
      send_request(kind, a, len, ext, pick_code(), 1'($urandom));
    end
    settle();
  endtask

  initial begin
    en_r = 0; base_r = 0; woff_r = 0; size_r = 0; win_r = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(250, 32'h600);
    set_region(1'b1, 64'hFFFF_FFFF_FFFF_F000, 32'd0, 32'hFFFF_FFFF, 64'd0);
    test_random(80, 32'hFF0);
    set_region(1'b1, 64'h0, 32'hFFFF_FFFF, 32'h10, 64'hFFFF_FFFF_FFFF_FFFF);
    test_random(40, 32'h100);
    set_region(1'b0, 64'h4000, 32'h8, 32'h2000, 64'h8000);
    calm = 1'b1;
    test_random(60, 32'h400);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
src/smac_pkg.sv
src/smac_datapath.sv
src/smac_ctrl.sv
src/shadow_memory_access_checker_core.sv
tb/tb_shadow_memory_access_checker_core.sv
